>>> hw/rtl/prq_pkg.sv
// prq_pkg: types and constants shared by the ready queue modules
// no dependencies
package prq_pkg;

    localparam int SLOT_W = 6;
    localparam int LVL_W  = 6;
    localparam int SLOTS  = 64;
    localparam int LEVELS = 64;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [LVL_W-1:0]  t_lvl;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_POP   = 2'd1,
        OP_MOVE  = 2'd2,
        OP_CHECK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_QUEUED    = 2'd2,
        STAT_NOT_QUEUED = 2'd3
    } t_status;

    // datapath step commanded by the controller
    typedef enum logic [2:0] {
        ST_NONE,
        ST_LOAD,
        ST_DECODE,
        ST_POP_B,
        ST_MV_B,
        ST_UNLINK,
        ST_MV_D,
        ST_APPEND
    } t_step;

    typedef struct packed {
        t_op  op;
        logic queued;
        logic any_ready;
        logic same_lvl;
    } t_dp_stat;

endpackage

>>> hw/rtl/prq_ram.sv
// prq_ram: generic single write port ram with registered read
// no dependencies
module prq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/prq_dpath.sv
// prq_dpath: link memories, queued and non-empty flags, result registers
// depends on prq_pkg and prq_ram
module prq_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prq_pkg::t_step   i_step,
    input  logic [1:0]       i_op,
    input  prq_pkg::t_slot   i_slot_id,
    input  prq_pkg::t_lvl    i_level,
    output prq_pkg::t_dp_stat o_stat,
    output prq_pkg::t_slot   o_out_slot,
    output logic             o_preempt,
    output logic [1:0]       o_status
);
    import prq_pkg::*;

    t_op   r_op;
    t_slot r_slot;
    t_lvl  r_lvl;
    t_lvl  r_ulvl;
    t_slot r_cur;
    logic [SLOTS-1:0]  r_queued;
    logic [LEVELS-1:0] r_nonempty;
    t_slot   r_out_slot;
    logic    r_preempt;
    t_status r_status;

    t_lvl  sl_q, hd_q_l;
    t_slot hd_q, tl_q, nx_q, pv_q;

    // read addresses
    t_slot sl_ra, nx_ra, pv_ra;
    t_lvl  hd_ra, tl_ra;
    // write ports
    logic  sl_we, nx_we, pv_we, hd_we, tl_we;
    t_slot sl_wa, nx_wa, pv_wa, nx_wd, pv_wd, hd_wd, tl_wd;
    t_lvl  hd_wa, tl_wa, sl_wd;

    t_lvl penc;
    logic above;
    logic is_head, is_tail;

    always_comb begin
        penc = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_nonempty[i]) penc = t_lvl'(i);
        end
        above = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_nonempty[i] && (t_lvl'(i) > r_lvl)) above = 1'b1;
        end
    end

    assign is_head = (hd_q == r_cur);
    assign is_tail = (tl_q == r_cur);

    always_comb begin
        sl_ra = r_slot;
        nx_ra = r_cur;
        pv_ra = r_cur;
        hd_ra = r_ulvl;
        tl_ra = r_ulvl;
        sl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
        sl_wa = r_slot; sl_wd = r_lvl;
        nx_wa = r_slot; nx_wd = r_slot;
        pv_wa = r_slot; pv_wd = r_slot;
        hd_wa = r_lvl;  hd_wd = r_slot;
        tl_wa = r_lvl;  tl_wd = r_slot;
        unique case (i_step)
            ST_DECODE: begin
                hd_ra = penc;
                tl_ra = (r_op == OP_ENQ) ? r_lvl : penc;
                if (r_op == OP_ENQ && !r_queued[r_slot]) nx_we = 1'b1;
            end
            ST_POP_B: begin
                nx_ra = hd_q;
                pv_ra = hd_q;
            end
            ST_MV_B: begin
                hd_ra = sl_q;
                tl_ra = sl_q;
                nx_ra = r_slot;
                pv_ra = r_slot;
            end
            ST_UNLINK: begin
                hd_wa = r_ulvl;
                tl_wa = r_ulvl;
                if (is_head && !is_tail) begin
                    hd_we = 1'b1; hd_wd = nx_q;
                    pv_we = 1'b1; pv_wa = nx_q; pv_wd = nx_q;
                end else if (is_tail && !is_head) begin
                    tl_we = 1'b1; tl_wd = pv_q;
                    nx_we = 1'b1; nx_wa = pv_q; nx_wd = pv_q;
                end else if (!is_head && !is_tail) begin
                    nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
                    pv_we = 1'b1; pv_wa = nx_q; pv_wd = pv_q;
                end
            end
            ST_MV_D: begin
                tl_ra = r_lvl;
                nx_we = 1'b1;
            end
            ST_APPEND: begin
                tl_we = 1'b1;
                sl_we = 1'b1;
                pv_we = 1'b1;
                if (r_nonempty[r_lvl]) begin
                    nx_we = 1'b1; nx_wa = tl_q; nx_wd = r_slot;
                    pv_wd = tl_q;
                end else begin
                    hd_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    prq_ram #(.WIDTH(LVL_W), .DEPTH(SLOTS)) u_slot_level (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_wa), .i_wdata(sl_wd),
        .i_raddr(sl_ra), .o_rdata(sl_q));
    prq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_q));
    prq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_q));
    prq_ram #(.WIDTH(SLOT_W), .DEPTH(LEVELS)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_q));
    prq_ram #(.WIDTH(SLOT_W), .DEPTH(LEVELS)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_raddr(tl_ra), .o_rdata(tl_q));

    assign hd_q_l = hd_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued   <= '0;
            r_nonempty <= '0;
        end else begin
            unique case (i_step)
                ST_UNLINK: begin
                    r_queued[r_cur] <= 1'b0;
                    if (is_head && is_tail) r_nonempty[r_ulvl] <= 1'b0;
                end
                ST_APPEND: begin
                    r_queued[r_slot]  <= 1'b1;
                    r_nonempty[r_lvl] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_step)
            ST_LOAD: begin
                r_op   <= t_op'(i_op);
                r_slot <= i_slot_id;
                r_lvl  <= i_level;
            end
            ST_DECODE: begin
                r_out_slot <= '0;
                r_preempt  <= (r_op == OP_CHECK) && above;
                r_ulvl     <= penc;
                unique case (r_op)
                    OP_ENQ:   r_status <= r_queued[r_slot] ? STAT_QUEUED : STAT_OK;
                    OP_POP:   r_status <= (|r_nonempty) ? STAT_OK : STAT_EMPTY;
                    OP_MOVE:  r_status <= r_queued[r_slot] ? STAT_OK : STAT_NOT_QUEUED;
                    OP_CHECK: r_status <= STAT_OK;
                endcase
            end
            ST_POP_B: begin
                r_cur      <= hd_q_l;
                r_out_slot <= hd_q;
            end
            ST_MV_B: begin
                r_cur  <= r_slot;
                r_ulvl <= sl_q;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.op        = r_op;
    assign o_stat.queued    = r_queued[r_slot];
    assign o_stat.any_ready = |r_nonempty;
    assign o_stat.same_lvl  = (sl_q == r_lvl);
    assign o_out_slot = r_out_slot;
    assign o_preempt  = r_preempt;
    assign o_status   = r_status;

    a_append_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step == ST_APPEND |=> r_nonempty[$past(r_lvl)] && r_queued[$past(r_slot)])
        else $error("append left level empty or slot not queued");
    a_unlink_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step == ST_UNLINK |=> !r_queued[$past(r_cur)])
        else $error("unlinked slot still marked queued");
    a_level_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_nonempty) |-> (|r_queued))
        else $error("non-empty level with no queued slot");
endmodule

>>> hw/rtl/prq_ctrl.sv
// prq_ctrl: sequencer for the ready queue operations
// depends on prq_pkg
module prq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  prq_pkg::t_dp_stat i_stat,
    output logic              busy,
    output prq_pkg::t_step    o_step,
    output logic              o_done
);
    import prq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_POP_B, S_MV_B, S_UNLINK, S_MV_D, S_APPEND
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_step  = ST_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_step  = ST_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_step = ST_DECODE;
                n_state = S_IDLE;
                n_done  = 1'b1;
                unique case (i_stat.op)
                    OP_ENQ: if (!i_stat.queued) begin
                        n_state = S_APPEND; n_done = 1'b0;
                    end
                    OP_POP: if (i_stat.any_ready) begin
                        n_state = S_POP_B; n_done = 1'b0;
                    end
                    OP_MOVE: if (i_stat.queued) begin
                        n_state = S_MV_B; n_done = 1'b0;
                    end
                    OP_CHECK: begin
                    end
                endcase
            end
            S_POP_B: begin
                o_step  = ST_POP_B;
                n_state = S_UNLINK;
            end
            S_MV_B: begin
                o_step = ST_MV_B;
                if (i_stat.same_lvl) begin
                    n_state = S_IDLE; n_done = 1'b1;
                end else begin
                    n_state = S_UNLINK;
                end
            end
            S_UNLINK: begin
                o_step = ST_UNLINK;
                if (i_stat.op == OP_MOVE) begin
                    n_state = S_MV_D;
                end else begin
                    n_state = S_IDLE; n_done = 1'b1;
                end
            end
            S_MV_D: begin
                o_step  = ST_MV_D;
                n_state = S_APPEND;
            end
            S_APPEND: begin
                o_step  = ST_APPEND;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
endmodule

>>> hw/rtl/priority_ready_queue.sv
// priority_ready_queue: ready queue of 64 slots over 64 priority levels
// depends on prq_pkg, prq_ctrl, prq_dpath
//
// Raise start with an operation while busy is low; one result comes back per
// item as a single-cycle o_valid pulse that cannot be stalled, so the receiver
// must take it on that cycle. Each step reads one link set of the per-level
// linked lists in single-port-read memories. Check and rejected or empty
// operations end after decode; enqueue appends; pop unlinks the head; a move
// to its own level ends after the link read; other moves unlink, read the
// tail and append. A new item may be started in the cycle o_valid is high.
module priority_ready_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_op,
    input  prq_pkg::t_slot      i_slot_id,
    input  prq_pkg::t_lvl       i_level,
    output logic                o_valid,
    output prq_pkg::t_slot      o_out_slot,
    output logic                o_preempt,
    output logic [1:0]          o_status
);
    import prq_pkg::*;

    t_step    step;
    t_dp_stat stat;

    prq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_stat(stat),
        .busy(busy), .o_step(step), .o_done(o_valid));

    prq_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_op(i_op),
        .i_slot_id(i_slot_id), .i_level(i_level), .o_stat(stat),
        .o_out_slot(o_out_slot), .o_preempt(o_preempt), .o_status(o_status));
endmodule
